// ===== design/cdfm_pkg.sv =====
// cdfm_pkg: shared types and codes of the CDF symbol mapper.
// No dependencies; used by the memories and the top level.
package cdfm_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_CDF = 2'd0;
  localparam logic [1:0] KIND_ROW = 2'd1;
  localparam logic [1:0] KIND_ENC = 2'd2;

  // Fixed field widths
  localparam int ROW_IN_W   = 6;
  localparam int ROW_IN_CNT = 1 << ROW_IN_W;
  localparam int CDF_W      = 17;
  localparam int LEN_W      = 9;
  localparam int WORD_W     = 32;
  localparam int OUT_W      = 16;
  // Piece count fits 0..32
  localparam int CNT_W      = 6;

  // Per-row setup word
  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [WORD_W-1:0] offset;
  } row_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FIRST,
    ST_COUNT,
    ST_CNT,
    ST_RAW
  } cdfm_state_e;

endpackage

// ===== design/cdf_symbol_mapper_with_escape.sv =====
// CDF symbol mapper with escape, front end of an rANS coder. Load
// transactions (kind 0: CDF entry, kind 1: row length and offset) and kind 3
// produce nothing. An encode reads the row store, then forms the value and
// reads the CDF pair, then loads the output register with its first result.
// An ordinary symbol yields that one result. An escape then counts its n raw
// pieces, and emits floor(n/PIECE_MAX)+1 count pieces plus n raw pieces at
// one per cycle while the receiver does not stall. Throughput is set by the
// two registered memory reads in series and the serial piece emitter; the
// input stalls until the last result of an encode is in the output register.
// There is no clearing pass after reset: table entries are undefined until
// written.
// Depends on cdfm_pkg, cdfm_row_mem and cdfm_cdf_mem.
module cdf_symbol_mapper_with_escape #(
  parameter int NUM_ROWS    = 64,
  parameter int ROW_ENTRIES = 256,
  parameter int PROB_BITS   = 16,
  parameter int BYPASS_BITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [5:0]          table_row_i,
  input  logic [7:0]          column_i,
  input  logic [16:0]         cdf_value_i,
  input  logic [8:0]          row_length_i,
  input  logic signed [31:0]  row_offset_i,
  input  logic signed [31:0]  symbol_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         start_res_o,
  output logic [15:0]         freq_o,
  output logic                is_bypass_o,
  output logic                last_o
);

  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W  = $clog2(ROW_ENTRIES);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = NUM_ROWS * (1 << COL_W);
  localparam int WW     = cdfm_pkg::WORD_W;
  localparam int OW     = cdfm_pkg::OUT_W;
  localparam int CW     = cdfm_pkg::CNT_W;

  localparam logic [WW-1:0] ENTRIES_W = WW'(ROW_ENTRIES);
  localparam logic [WW-1:0] LEN_MIN   = WW'(2);
  localparam logic [OW-1:0] PIECE_MAX = OW'((1 << BYPASS_BITS) - 1);

  // ---------------------------------------------------------------------
  // Row index folding: the 6-bit row field is taken modulo NUM_ROWS through
  // a constant table built at elaboration.
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] row_map [cdfm_pkg::ROW_IN_CNT];

  for (genvar g = 0; g < cdfm_pkg::ROW_IN_CNT; g++) begin : g_row_map
    assign row_map[g] = ROW_W'(g % NUM_ROWS);
  end

  // ---------------------------------------------------------------------
  // Input side: loads write straight into the stores on acceptance; an
  // encode starts the row read. The input stalls while an encode is in
  // flight, so no table access can overlap a pending read.
  // ---------------------------------------------------------------------
  cdfm_pkg::cdfm_state_e state_q, state_d;

  logic             in_acc;
  logic [ROW_W-1:0] row_idx;
  logic [WW-1:0]    col_ext;
  logic             col_ok;

  assign in_stall_o = (state_q != cdfm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign row_idx    = row_map[table_row_i];
  assign col_ext    = WW'(column_i);
  assign col_ok     = (col_ext < ENTRIES_W);

  logic                 row_we;
  logic                 row_re;
  cdfm_pkg::row_entry_t row_wdata;
  cdfm_pkg::row_entry_t row_rdata;

  assign row_we    = in_acc && (kind_i == cdfm_pkg::KIND_ROW);
  assign row_re    = in_acc && (kind_i == cdfm_pkg::KIND_ENC);
  assign row_wdata = {row_length_i, row_offset_i};

  cdfm_row_mem #(
    .DEPTH  (NUM_ROWS),
    .ADDR_W (ROW_W)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_idx),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_idx),
    .rdata_o (row_rdata)
  );

  // Encode operands held for the whole transaction
  logic [WW-1:0]    sym_q;
  logic [ROW_W-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (row_re) begin
      sym_q <= symbol_i;
      row_q <= row_idx;
    end
  end

  // ---------------------------------------------------------------------
  // Look stage: value = symbol - offset (mod 2^32), length clamped to
  // [2, ROW_ENTRIES], escape when negative or >= length-2.
  // ---------------------------------------------------------------------
  logic [WW-1:0]    len_ext;
  logic [WW-1:0]    len_c;
  logic [WW-1:0]    maxv;
  logic [WW-1:0]    val;
  logic             esc_neg;
  logic             esc;
  logic [COL_W-1:0] idx;
  logic [COL_W-1:0] idx_nx;

  always_comb begin
    len_ext = WW'(row_rdata.length);
    if (len_ext < LEN_MIN) begin
      len_c = LEN_MIN;
    end else if (len_ext > ENTRIES_W) begin
      len_c = ENTRIES_W;
    end else begin
      len_c = len_ext;
    end
    maxv    = len_c - LEN_MIN;
    val     = sym_q - row_rdata.offset;
    esc_neg = val[WW-1];
    esc     = esc_neg || (val >= maxv);
    idx     = esc ? maxv[COL_W-1:0] : val[COL_W-1:0];
    idx_nx  = idx + COL_W'(1);
  end

  logic cdf_we;
  logic cdf_re;
  logic [cdfm_pkg::CDF_W-1:0] cdf_lo;
  logic [cdfm_pkg::CDF_W-1:0] cdf_hi;

  assign cdf_we = in_acc && (kind_i == cdfm_pkg::KIND_CDF) && col_ok;
  assign cdf_re = (state_q == cdfm_pkg::ST_LOOK);

  cdfm_cdf_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_cdf_mem (
    .clk_i     (clk_i),
    .we_i      (cdf_we),
    .waddr_i   ({row_idx, col_ext[COL_W-1:0]}),
    .wdata_i   (cdf_value_i),
    .re_i      (cdf_re),
    .raddr_a_i ({row_q, idx}),
    .raddr_b_i ({row_q, idx_nx}),
    .rdata_a_o (cdf_lo),
    .rdata_b_o (cdf_hi)
  );

  logic [WW-1:0]    val_q;
  logic [COL_W-1:0] maxv_q;
  logic             neg_q;
  logic             esc_q;

  always_ff @(posedge clk_i) begin
    if (cdf_re) begin
      val_q  <= val;
      maxv_q <= maxv[COL_W-1:0];
      neg_q  <= esc_neg;
      esc_q  <= esc;
    end
  end

  // ---------------------------------------------------------------------
  // First result and raw escape value.
  // negative v: -2v-1 == ~(2v); overflow: 2*(v - maxv), both mod 2^32.
  // ---------------------------------------------------------------------
  logic [cdfm_pkg::CDF_W-1:0] cdf_diff;
  logic [WW-1:0]              over;
  logic [WW-1:0]              raw;

  assign cdf_diff = cdf_hi - cdf_lo;
  assign over     = val_q - WW'(maxv_q);
  assign raw      = neg_q ? ~{val_q[WW-2:0], 1'b0} : {over[WW-2:0], 1'b0};

  // ---------------------------------------------------------------------
  // Escape sequencer and output register
  // ---------------------------------------------------------------------
  logic [WW-1:0] work_q, work_d;   // count loop shifter
  logic [CW-1:0] n_q, n_d;         // number of raw pieces
  logic [CW-1:0] cnt_q, cnt_d;     // count still to emit
  logic [CW-1:0] j_q, j_d;         // raw pieces emitted
  logic [WW-1:0] raw_q, raw_d;

  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] start_q, start_d;
  logic [OW-1:0] freq_q, freq_d;
  logic          byp_q, byp_d;
  logic          last_q, last_d;
  logic          out_free;

  logic [OW-1:0] cnt_ext;
  logic [OW-1:0] piece;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_ext  = OW'(cnt_q);
  assign piece    = OW'(raw_q[BYPASS_BITS-1:0]);

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    raw_d       = raw_q;
    out_valid_d = out_valid_q && out_stall_i;
    start_d     = start_q;
    freq_d      = freq_q;
    byp_d       = byp_q;
    last_d      = last_q;

    case (state_q)
      cdfm_pkg::ST_IDLE: begin
        if (row_re) begin
          state_d = cdfm_pkg::ST_LOOK;
        end
      end
      cdfm_pkg::ST_LOOK: begin
        state_d = cdfm_pkg::ST_FIRST;
      end
      cdfm_pkg::ST_FIRST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          start_d     = OW'(cdf_lo[PROB_BITS-1:0]);
          freq_d      = OW'(cdf_diff[PROB_BITS-1:0]);
          byp_d       = 1'b0;
          last_d      = !esc_q;
          raw_d       = raw;
          work_d      = raw;
          n_d         = '0;
          j_d         = '0;
          state_d     = esc_q ? cdfm_pkg::ST_COUNT : cdfm_pkg::ST_IDLE;
        end
      end
      cdfm_pkg::ST_COUNT: begin
        // one piece per cycle until the shifted value is empty
        if (work_q == '0) begin
          cnt_d   = n_q;
          state_d = cdfm_pkg::ST_CNT;
        end else begin
          work_d = work_q >> BYPASS_BITS;
          n_d    = n_q + CW'(1);
        end
      end
      cdfm_pkg::ST_CNT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byp_d       = 1'b1;
          if (cnt_ext >= PIECE_MAX) begin
            start_d = PIECE_MAX;
            freq_d  = PIECE_MAX + OW'(1);
            last_d  = 1'b0;
            cnt_d   = CW'(cnt_ext - PIECE_MAX);
          end else begin
            start_d = cnt_ext;
            freq_d  = cnt_ext + OW'(1);
            last_d  = (n_q == '0);
            state_d = (n_q == '0) ? cdfm_pkg::ST_IDLE : cdfm_pkg::ST_RAW;
          end
        end
      end
      cdfm_pkg::ST_RAW: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byp_d       = 1'b1;
          start_d     = piece;
          freq_d      = piece + OW'(1);
          last_d      = (j_q + CW'(1) == n_q);
          raw_d       = raw_q >> BYPASS_BITS;
          j_d         = j_q + CW'(1);
          if (j_q + CW'(1) == n_q) begin
            state_d = cdfm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = cdfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdfm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    n_q     <= n_d;
    cnt_q   <= cnt_d;
    j_q     <= j_d;
    raw_q   <= raw_d;
    start_q <= start_d;
    freq_q  <= freq_d;
    byp_q   <= byp_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign start_res_o = start_q;
  assign freq_o      = freq_q;
  assign is_bypass_o = byp_q;
  assign last_o      = last_q;

endmodule

// ===== design/cdfm_row_mem.sv =====
// cdfm_row_mem: per-row length and offset store, one write and one read port.
// Depends on cdfm_pkg for row_entry_t.
module cdfm_row_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  cdfm_pkg::row_entry_t  wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output cdfm_pkg::row_entry_t  rdata_o
);

  cdfm_pkg::row_entry_t mem [DEPTH];
  cdfm_pkg::row_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cdfm_cdf_mem.sv =====
// cdfm_cdf_mem: CDF table, one write port and two registered read ports
// (entry and its successor). Depends on cdfm_pkg for the entry width.
module cdfm_cdf_mem #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [cdfm_pkg::CDF_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_a_i,
  input  logic [ADDR_W-1:0]           raddr_b_i,
  output logic [cdfm_pkg::CDF_W-1:0]  rdata_a_o,
  output logic [cdfm_pkg::CDF_W-1:0]  rdata_b_o
);

  logic [cdfm_pkg::CDF_W-1:0] mem [DEPTH];
  logic [cdfm_pkg::CDF_W-1:0] rdata_a_q;
  logic [cdfm_pkg::CDF_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sim/cdfm_result_checker.sv =====
`timescale 1ns / 1ps
// cdfm_result_checker: watches both channels of the CDF symbol mapper, keeps
// its own copy of the tables, predicts the coder entries and compares them.
// Depends on cdfm_pkg for the transaction kinds and field widths.
module cdfm_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         kind_i,
  input  logic [5:0]         table_row_i,
  input  logic [7:0]         column_i,
  input  logic [16:0]        cdf_value_i,
  input  logic [8:0]         row_length_i,
  input  logic [31:0]        row_offset_i,
  input  logic [31:0]        symbol_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [15:0]        start_res_i,
  input  logic [15:0]        freq_i,
  input  logic               is_bypass_i,
  input  logic               last_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  localparam int ENTRIES   = 256;
  localparam int PIECE_W   = 4;
  localparam int PIECE_MAX = (1 << PIECE_W) - 1;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] freq;
    logic        bypass;
    logic        last;
  } coder_entry_t;

  logic [cdfm_pkg::CDF_W-1:0]  cdf_tab [0:cdfm_pkg::ROW_IN_CNT*ENTRIES-1];
  logic [cdfm_pkg::LEN_W-1:0]  len_tab [0:cdfm_pkg::ROW_IN_CNT-1];
  logic [cdfm_pkg::WORD_W-1:0] off_tab [0:cdfm_pkg::ROW_IN_CNT-1];

  coder_entry_t expected_q [$];
  coder_entry_t want_e;
  coder_entry_t got_e;
  int           mismatches = 0;

  function automatic coder_entry_t mk_entry(input logic [15:0] s, input logic [15:0] f,
                                            input logic b, input logic l);
    coder_entry_t e;
    e.start  = s;
    e.freq   = f;
    e.bypass = b;
    e.last   = l;
    return e;
  endfunction

  // Appends one predicted entry at the tail of the expected queue.
  function automatic void add_expected(input coder_entry_t e);
    expected_q = {expected_q, e};
  endfunction

  // Lookup of one symbol plus the escape tail (count pieces, then raw nibbles).
  task automatic map_symbol(input logic [5:0] row, input logic [31:0] sym);
    int unsigned                len;
    int unsigned                maxv;
    int unsigned                n;
    int unsigned                cnt;
    logic [31:0]                val;
    logic [31:0]                raw;
    logic                       escape;
    logic [7:0]                 idx;
    logic [cdfm_pkg::CDF_W-1:0] lo;
    logic [cdfm_pkg::CDF_W-1:0] hi;
    logic [cdfm_pkg::CDF_W-1:0] diff;
    logic [3:0]                 nib;
    len = len_tab[row];
    if (len < 2) len = 2;
    if (len > ENTRIES) len = ENTRIES;
    maxv = len - 2;
    val = sym - off_tab[row];
    escape = 1'b1;
    raw = '0;
    if (val[31]) begin
      raw = 32'd0 - (val << 1) - 32'd1;
    end else if (val >= maxv) begin
      raw = (val - maxv) << 1;
    end else begin
      escape = 1'b0;
    end
    idx  = escape ? maxv[7:0] : val[7:0];
    lo   = cdf_tab[{row, idx}];
    hi   = cdf_tab[{row, idx + 8'd1}];
    diff = hi - lo;
    add_expected(mk_entry(lo[15:0], diff[15:0], 1'b0, !escape));
    if (escape) begin
      n = 0;
      while (n < 8 && (raw >> (PIECE_W * n)) != 0) n++;
      cnt = n;
      while (cnt >= PIECE_MAX) begin
        add_expected(mk_entry(16'(PIECE_MAX), 16'(PIECE_MAX + 1), 1'b1, 1'b0));
        cnt -= PIECE_MAX;
      end
      add_expected(mk_entry(16'(cnt), 16'(cnt + 1), 1'b1, n == 0));
      for (int j = 0; j < n; j++) begin
        nib = raw[PIECE_W*j +: PIECE_W];
        add_expected(mk_entry(16'(nib), 16'(nib) + 16'd1, 1'b1, j + 1 == n));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (kind_i)
          cdfm_pkg::KIND_CDF: cdf_tab[{table_row_i, column_i}] = cdf_value_i;
          cdfm_pkg::KIND_ROW: begin
            len_tab[table_row_i] = row_length_i;
            off_tab[table_row_i] = row_offset_i;
          end
          cdfm_pkg::KIND_ENC: map_symbol(table_row_i, symbol_i);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got_e = mk_entry(start_res_i, freq_i, is_bypass_i, last_i);
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("cdfm check: unexpected entry start=%h freq=%h byp=%b last=%b",
                     got_e.start, got_e.freq, got_e.bypass, got_e.last);
          mismatches++;
        end else begin
          want_e = expected_q.pop_front();
          if (got_e !== want_e) begin
            if (mismatches < 10)
              $display("cdfm check: entry mismatch exp start=%h freq=%h byp=%b last=%b %s",
                       want_e.start, want_e.freq, want_e.bypass, want_e.last,
                       $sformatf("got start=%h freq=%h byp=%b last=%b",
                                 got_e.start, got_e.freq, got_e.bypass, got_e.last));
            mismatches++;
          end
        end
      end
      pending_o        <= expected_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== sim/cdf_symbol_mapper_with_escape_test.sv =====
`timescale 1ns / 1ps
// cdf_symbol_mapper_with_escape_test: stimulus and verdict for the CDF symbol
// mapper; checking is done by cdfm_result_checker. Depends on cdfm_pkg.
module cdf_symbol_mapper_with_escape_test;

  // Kind 3 is not a defined transaction; the block drops it.
  localparam logic [1:0] KIND_NONE = 2'd3;
  // Cycles with no transaction on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 4000;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 150;
  // Drain time after the last expected entry has arrived.
  localparam int TAIL_CYCLES = 30;
  localparam int ENTRIES = 256;
  localparam int ROWS = cdfm_pkg::ROW_IN_CNT;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         kind_i;
  logic [5:0]         table_row_i;
  logic [7:0]         column_i;
  logic [16:0]        cdf_value_i;
  logic [8:0]         row_length_i;
  logic signed [31:0] row_offset_i;
  logic signed [31:0] symbol_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        start_res_o;
  logic [15:0]        freq_o;
  logic               is_bypass_o;
  logic               last_o;

  int mismatch_count;
  int pending_count;

  // Traffic shaping knobs, changed per phase by the main sequence, and counters of sent items and quiet cycles.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_cycles    = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  // Bookkeeping of what has been loaded, so that an encode never touches a
  // table entry before it has been written.
  bit          cdf_written [ROWS][ENTRIES];
  bit          row_ready   [ROWS];
  int unsigned row_eff_len [ROWS];
  logic [31:0] row_off     [ROWS];

  cdf_symbol_mapper_with_escape dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .table_row_i  (table_row_i),
    .column_i     (column_i),
    .cdf_value_i  (cdf_value_i),
    .row_length_i (row_length_i),
    .row_offset_i (row_offset_i),
    .symbol_i     (symbol_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .start_res_o  (start_res_o),
    .freq_o       (freq_o),
    .is_bypass_o  (is_bypass_o),
    .last_o       (last_o)
  );

  cdfm_result_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .table_row_i      (table_row_i),
    .column_i         (column_i),
    .cdf_value_i      (cdf_value_i),
    .row_length_i     (row_length_i),
    .row_offset_i     (row_offset_i),
    .symbol_i         (symbol_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .start_res_i      (start_res_o),
    .freq_i           (freq_o),
    .is_bypass_i      (is_bypass_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // One transaction on the input channel. An optional idle gap comes first;
  // valid is left high afterwards so back-to-back transactions need no bubble.
  task automatic send_item(input logic [1:0] kind, input logic [5:0] row,
                           input logic [7:0] col, input logic [16:0] cv,
                           input logic [8:0] len, input logic [31:0] off,
                           input logic [31:0] sym);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    table_row_i  <= row;
    column_i     <= col;
    cdf_value_i  <= cv;
    row_length_i <= len;
    row_offset_i <= off;
    symbol_i     <= sym;
    // Payload holds until the block takes it.
    do @(posedge clk_i); while (in_stall_o);
    if (kind != KIND_NONE) items_sent++;
  endtask

  // Unused fields of each kind carry random junk; the block must ignore it.
  task automatic load_cdf(input logic [5:0] row, input logic [7:0] col,
                          input logic [16:0] val);
    send_item(cdfm_pkg::KIND_CDF, row, col, val, 9'($urandom), $urandom, $urandom);
    cdf_written[row][col] = 1'b1;
  endtask

  task automatic load_row(input logic [5:0] row, input logic [8:0] len,
                          input logic [31:0] off);
    send_item(cdfm_pkg::KIND_ROW, row, 8'($urandom), 17'($urandom), len, off, $urandom);
    row_ready[row]   = 1'b1;
    // stored length is clamped to 2..ENTRIES at use
    row_eff_len[row] = (len < 2) ? 2 : (len > ENTRIES) ? ENTRIES : len;
    row_off[row]     = off;
  endtask

  task automatic encode(input logic [5:0] row, input logic [31:0] sym);
    send_item(cdfm_pkg::KIND_ENC, row, 8'($urandom), 17'($urandom), 9'($urandom),
              $urandom, sym);
  endtask

  // Well-formed row setup: length and offset, then the CDF entries that any
  // encode on this row may read. Short rows get every entry, long rows only
  // the escape pair plus a few scattered ones.
  task automatic setup_random_row();
    int unsigned row;
    int unsigned len;
    int unsigned eff;
    logic [31:0] off;
    row = $urandom_range(0, ROWS - 1);
    case ($urandom_range(0, 9))
      0: len = $urandom_range(13, 511);
      1: len = $urandom_range(0, 1);
      default: len = $urandom_range(2, 12);
    endcase
    off = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 20)) - 32'd10;
    load_row(6'(row), 9'(len), off);
    eff = row_eff_len[row];
    if (eff <= 16) begin
      for (int c = 0; c < eff; c++) load_cdf(6'(row), 8'(c), 17'($urandom));
    end else begin
      load_cdf(6'(row), 8'(eff - 2), 17'($urandom));
      load_cdf(6'(row), 8'(eff - 1), 17'($urandom));
      repeat (4) load_cdf(6'(row), 8'($urandom_range(0, ENTRIES - 1)), 17'($urandom));
    end
  endtask

  // Encode on a loaded row: in-range lookups, exact escape boundary,
  // overflow escapes and negative escapes, both near and far.
  task automatic encode_random();
    int unsigned row;
    int unsigned maxv;
    int unsigned cand;
    int          pick;
    logic [31:0] v;
    do row = $urandom_range(0, ROWS - 1); while (!row_ready[row]);
    maxv = row_eff_len[row] - 2;
    pick = $urandom_range(0, 99);
    v    = maxv;
    if (pick < 45) begin
      if (maxv > 0) begin
        for (int t = 0; t < 8; t++) begin
          cand = $urandom_range(0, maxv - 1);
          if (cdf_written[row][cand] && cdf_written[row][cand + 1]) begin
            v = cand;
            break;
          end
        end
      end
    end else if (pick < 60) begin
      v = maxv;
    end else if (pick < 80) begin
      v = maxv + ($urandom_range(0, 1) ? $urandom_range(1, 40)
                                       : $urandom_range(0, 32'h7FFF_FFFF - maxv));
    end else begin
      v = $urandom_range(0, 1) ? 32'd0 - $urandom_range(1, 40) : {1'b1, 31'($urandom)};
    end
    encode(6'(row), v + row_off[row]);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      setup_random_row();
    else if (pick < 18)
      load_cdf(6'($urandom_range(0, ROWS - 1)), 8'($urandom_range(0, ENTRIES - 1)),
               17'($urandom));
    else if (pick < 21)
      send_item(KIND_NONE, 6'($urandom), 8'($urandom), 17'($urandom), 9'($urandom),
                $urandom, $urandom);
    else
      encode_random();
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int count);
    int target;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    target         = items_sent + count;
    while (items_sent < target) random_item();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= cdfm_pkg::KIND_CDF;
    table_row_i  <= '0;
    column_i     <= '0;
    cdf_value_i  <= '0;
    row_length_i <= '0;
    row_offset_i <= '0;
    symbol_i     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: row 0, length 4, zero offset. CDF extremes incl. 17-bit max.
    load_row(6'd0, 9'd4, 32'd0);
    load_cdf(6'd0, 8'd0, 17'h00000);
    load_cdf(6'd0, 8'd1, 17'h1FFFF);
    load_cdf(6'd0, 8'd2, 17'h00005);
    load_cdf(6'd0, 8'd3, 17'h10000);
    encode(6'd0, 32'd0);              // plain lookup, frequency truncated to 16 bits
    encode(6'd0, 32'd1);              // plain lookup, start truncated to 16 bits
    encode(6'd0, 32'd2);              // exactly length-2: escape with zero raw value
    encode(6'd0, 32'd3);              // just past the top
    encode(6'd0, 32'hFFFF_FFFF);      // -1: negative escape
    encode(6'd0, 32'h7FFF_FFFF);      // largest positive: eight raw nibbles
    encode(6'd0, 32'h8000_0000);      // most negative: raw wraps to all ones
    // Length below 2 clamps up; negative offset.
    load_row(6'd5, 9'd1, 32'hFFFF_FFFB);
    load_cdf(6'd5, 8'd0, 17'h0ABCD);
    load_cdf(6'd5, 8'd1, 17'h0ABCE);
    encode(6'd5, 32'hFFFF_FFFB);      // value 0 equals length-2 after clamping
    encode(6'd5, 32'hFFFF_FFFC);      // overflow escape
    // Top row, length field all ones clamps to 256, offset at the signed minimum.
    load_row(6'd63, 9'h1FF, 32'h8000_0000);
    load_cdf(6'd63, 8'd254, 17'h00000);
    load_cdf(6'd63, 8'd255, 17'h1FFFF);
    encode(6'd63, 32'h7FFF_FFFF);     // value wraps to -1
    encode(6'd63, 32'h8000_00FE);     // value 254, the escape boundary of a full row
    send_item(KIND_NONE, 6'h3F, 8'hFF, 17'h1FFFF, 9'h1FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random phases with different traffic shapes.
    run_phase(0, 0, 55);
    run_phase(78, 0, 55);
    // Back-pressure: the receiver holds off while the sender keeps pushing
    // encodes, so the block fills and stalls its input.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = HOLD_OFF_CYCLES;
    repeat (30) encode_random();
    run_phase(0, 78, 55);
    run_phase(15, 15, 55);

    in_valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/cdfm_pkg.sv
design/cdfm_row_mem.sv
design/cdfm_cdf_mem.sv
design/cdf_symbol_mapper_with_escape.sv
sim/cdfm_result_checker.sv
sim/cdf_symbol_mapper_with_escape_test.sv
